/* rtl/bbq_pkg.sv */
package bbq_pkg;

    localparam int CRD_W   = 20;
    localparam int VEC_W   = 3 * CRD_W;
    localparam int DIR_W   = CRD_W + 1;
    localparam int RAD_W   = 2 * DIR_W;
    localparam int ROOT_W  = DIR_W;
    localparam int REM_W   = ROOT_W + 2;
    localparam int QUO_W   = 15;
    localparam int DREM_W  = DIR_W + QUO_W + 1;
    localparam int NRM_W   = 16;
    localparam int SID_W   = 18;
    localparam int PRD_W   = 36;
    localparam int OFS_W   = 22;
    localparam int SUM_W   = 24;
    localparam int SIZE_W  = 16;

    localparam int RT_STEPS = ROOT_W;
    localparam int RT_PER   = 3;
    localparam int RT_ST    = RT_STEPS / RT_PER;
    localparam int DV_STEPS = QUO_W;
    localparam int DV_PER   = 3;
    localparam int DV_ST    = DV_STEPS / DV_PER;

    localparam int ST_REL   = 0;
    localparam int ST_DIR   = 1;
    localparam int ST_SQ_A  = 2;
    localparam int ST_SUM_A = 3;
    localparam int ST_RT_A  = 4;
    localparam int ST_DI_A  = ST_RT_A + RT_ST;
    localparam int ST_DV_A  = ST_DI_A + 1;
    localparam int ST_NRM   = ST_DV_A + DV_ST;
    localparam int ST_SQ_B  = ST_NRM + 1;
    localparam int ST_SUM_B = ST_SQ_B + 1;
    localparam int ST_RT_B  = ST_SUM_B + 1;
    localparam int ST_DI_B  = ST_RT_B + RT_ST;
    localparam int ST_DV_B  = ST_DI_B + 1;
    localparam int ST_S1    = ST_DV_B + DV_ST;
    localparam int ST_XMUL  = ST_S1 + 1;
    localparam int ST_XRND  = ST_XMUL + 1;
    localparam int ST_SMUL  = ST_XRND + 1;
    localparam int ST_SRND  = ST_SMUL + 1;
    localparam int NUM_ST   = ST_SRND + 1;

    localparam logic [2:0] REG_ALIGN_MODE    = 3'd0;
    localparam logic [2:0] REG_CUSTOM_AXIS   = 3'd1;
    localparam logic [2:0] REG_CAMERA_EYE    = 3'd2;
    localparam logic [2:0] REG_CAMERA_AXIS   = 3'd3;
    localparam logic [2:0] REG_SYSTEM_OFFSET = 3'd4;

    localparam logic [1:0] ALIGN_SCREEN = 2'd0;
    localparam logic [1:0] ALIGN_CAMERA = 2'd1;
    localparam logic [1:0] ALIGN_ZLOCK  = 2'd2;
    localparam logic [1:0] ALIGN_CUSTOM = 2'd3;

    localparam logic [VEC_W-1:0] CUSTOM_AXIS_RST = VEC_W'(256);

    localparam logic [1:0] CORNER_FIRST = 2'd0;
    localparam logic [1:0] CORNER_LAST  = 2'd3;

    localparam logic [SID_W-1:0] Q14_ONE = SID_W'(16384);

    typedef struct packed {
        logic [2:0][CRD_W-1:0]  pos;
        logic [SIZE_W-1:0]      size;
        logic                   last;
        logic [2:0][DIR_W-1:0]  dir;
        logic [2:0][RAD_W-1:0]  sq;
        logic [RAD_W-1:0]       rad;
        logic [ROOT_W-1:0]      root;
        logic [REM_W-1:0]       rem;
        logic [2:0][DREM_W-1:0] drem;
        logic [2:0][QUO_W-1:0]  quo;
        logic [2:0]             neg;
        logic [2:0][NRM_W-1:0]  nrm;
        logic [2:0][SID_W-1:0]  s1;
        logic [2:0][SID_W-1:0]  s2;
        logic [2:0][PRD_W-1:0]  xp;
        logic [5:0][PRD_W-1:0]  sp;
        logic [5:0][OFS_W-1:0]  pp;
    } item_t;

    function automatic logic [CRD_W-1:0] sat_crd(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = SUM_W'(524287);
        lo = -SUM_W'(524288);
        if (v > hi) begin
            return CRD_W'(hi);
        end else if (v < lo) begin
            return CRD_W'(lo);
        end
        return v[CRD_W-1:0];
    endfunction

    function automatic logic [OFS_W-1:0] rnd14(input logic signed [PRD_W-1:0] v);
        logic [PRD_W-1:0] mag;
        logic [PRD_W-1:0] r;
        logic [OFS_W-1:0] m;
        mag = v[PRD_W-1] ? (~v + PRD_W'(1)) : v;
        r = (mag + PRD_W'(8192)) >> 14;
        m = r[OFS_W-1:0];
        return v[PRD_W-1] ? (~m + OFS_W'(1)) : m;
    endfunction

    function automatic item_t rt_steps(input item_t x, input int s);
        item_t y;
        logic [REM_W-1:0] rt;
        logic [REM_W-1:0] trial;
        int st;
        y = x;
        for (int j = 0; j < RT_PER; j++) begin
            st = s * RT_PER + j;
            rt = {y.rem[REM_W-3:0], y.rad[RAD_W-1-2*st -: 2]};
            trial = {y.root, 2'b01};
            if (rt >= trial) begin
                y.rem = rt - trial;
                y.root = {y.root[ROOT_W-2:0], 1'b1};
            end else begin
                y.rem = rt;
                y.root = {y.root[ROOT_W-2:0], 1'b0};
            end
        end
        return y;
    endfunction

    function automatic item_t dv_steps(input item_t x, input int s);
        item_t y;
        logic [DREM_W-1:0] dd;
        int b;
        y = x;
        for (int j = 0; j < DV_PER; j++) begin
            b = DV_STEPS - 1 - (s * DV_PER + j);
            dd = DREM_W'({x.root, 1'b0}) << b;
            for (int i = 0; i < 3; i++) begin
                if (y.drem[i] >= dd) begin
                    y.drem[i] = y.drem[i] - dd;
                    y.quo[i][b] = 1'b1;
                end
            end
        end
        return y;
    endfunction

    function automatic item_t div_init(input item_t x);
        item_t y;
        logic [DIR_W-1:0] mag;
        y = x;
        for (int i = 0; i < 3; i++) begin
            mag = x.dir[i][DIR_W-1] ? (~x.dir[i] + DIR_W'(1)) : x.dir[i];
            y.drem[i] = {1'b0, mag, {QUO_W{1'b0}}} + DREM_W'(x.root);
            y.quo[i] = '0;
            y.neg[i] = x.dir[i][DIR_W-1];
        end
        return y;
    endfunction

    function automatic item_t sq_sum(input item_t x, input logic do_sum);
        item_t y;
        logic signed [RAD_W-1:0] e;
        y = x;
        if (do_sum) begin
            y.rad = x.sq[0] + x.sq[1] + x.sq[2];
            y.root = '0;
            y.rem = '0;
        end else begin
            for (int i = 0; i < 3; i++) begin
                e = RAD_W'($signed(x.dir[i]));
                y.sq[i] = e * e;
            end
        end
        return y;
    endfunction

endpackage

/* rtl/billboard_quad_generator.sv */
// Billboard quad generator.
// Input channel (s_valid/s_ready): one beat carries one particle, its position,
// half extent and end-of-set flag. Result channel (m_valid/m_ready): four
// beats per particle, corners 0 to 3 in order, each with the shared normal;
// last_corner marks corner 3 and end_of_set marks corner 3 of the final
// particle.
// Configuration: cfg_we writes cfg_wdata into register cfg_index (0 align
// mode, 1 custom axis, 2 camera eye, 3 camera axis, 4 system offset); other
// indexes are ignored. Write only while no particle is in flight.
// Particles pass through a 38 stage pipeline (two square root and two divide
// sections, three result bits per stage). The result channel moves one corner
// per beat, so a new particle is taken only when the output stage is empty or
// hands over its last corner; the pipeline then advances as a whole.
// Reset clears all stage valid bits, the corner counter and the registers to
// their reset values. When the receiver stalls, the current corner holds and
// the whole pipeline freezes, so s_ready drops until the stall clears.
module billboard_quad_generator
    import bbq_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_we,
    input  logic [2:0]               cfg_index,
    input  logic [VEC_W-1:0]         cfg_wdata,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic signed [CRD_W-1:0]  s_pos_x,
    input  logic signed [CRD_W-1:0]  s_pos_y,
    input  logic signed [CRD_W-1:0]  s_pos_z,
    input  logic [SIZE_W-1:0]        s_sprite_size,
    input  logic                     s_last_particle,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [1:0]               m_corner_index,
    output logic signed [CRD_W-1:0]  m_vert_x,
    output logic signed [CRD_W-1:0]  m_vert_y,
    output logic signed [CRD_W-1:0]  m_vert_z,
    output logic signed [NRM_W-1:0]  m_norm_x,
    output logic signed [NRM_W-1:0]  m_norm_y,
    output logic signed [NRM_W-1:0]  m_norm_z,
    output logic                     m_last_corner,
    output logic                     m_end_of_set
);

    logic [1:0]       align_mode_reg;
    logic [VEC_W-1:0] custom_axis_reg;
    logic [VEC_W-1:0] camera_eye_reg;
    logic [VEC_W-1:0] camera_axis_reg;
    logic [VEC_W-1:0] system_offset_reg;

    item_t             in_item;
    item_t             st_reg  [NUM_ST];
    item_t             st_next [NUM_ST];
    logic [NUM_ST-1:0] vld_reg;
    logic [NUM_ST-1:0] vld_next;
    logic [1:0]        cnt_reg;
    logic [1:0]        cnt_next;
    logic              adv;
    item_t             oi;
    logic [2:0][CRD_W-1:0] vert;

    function automatic item_t stage_fn(input int k, input item_t x, input logic [1:0] mode,
                                       input logic [VEC_W-1:0] eye, input logic [VEC_W-1:0] cax,
                                       input logic [VEC_W-1:0] cus, input logic [VEC_W-1:0] off);
        item_t y;
        logic signed [SUM_W-1:0] t;
        logic signed [DIR_W-1:0] d;
        logic signed [NRM_W-1:0] n;
        logic signed [NRM_W-1:0] q;
        logic signed [PRD_W-1:0] pa;
        logic signed [PRD_W-1:0] pb;
        logic signed [PRD_W-1:0] sz;
        logic [OFS_W-1:0] r;
        y = x;
        if (k == ST_REL) begin
            for (int i = 0; i < 3; i++) begin
                t = SUM_W'($signed(x.pos[i])) - SUM_W'($signed(off[CRD_W*i +: CRD_W]));
                y.pos[i] = sat_crd(t);
            end
        end else if (k == ST_DIR) begin
            for (int i = 0; i < 3; i++) begin
                case (mode)
                    ALIGN_SCREEN: d = -DIR_W'($signed(cax[CRD_W*i +: CRD_W]));
                    ALIGN_CAMERA, ALIGN_ZLOCK:
                        d = DIR_W'($signed(eye[CRD_W*i +: CRD_W]))
                            - DIR_W'($signed(x.pos[i]));
                    default: d = DIR_W'($signed(cus[CRD_W*i +: CRD_W]));
                endcase
                y.dir[i] = d;
            end
            if (mode == ALIGN_ZLOCK) begin
                y.dir[2] = '0;
            end
        end else if (k == ST_SQ_A || k == ST_SQ_B) begin
            y = sq_sum(x, 1'b0);
        end else if (k == ST_SUM_A || k == ST_SUM_B) begin
            y = sq_sum(x, 1'b1);
        end else if (k >= ST_RT_A && k < ST_RT_A + RT_ST) begin
            y = rt_steps(x, k - ST_RT_A);
        end else if (k >= ST_RT_B && k < ST_RT_B + RT_ST) begin
            y = rt_steps(x, k - ST_RT_B);
        end else if (k == ST_DI_A || k == ST_DI_B) begin
            y = div_init(x);
        end else if (k >= ST_DV_A && k < ST_DV_A + DV_ST) begin
            y = dv_steps(x, k - ST_DV_A);
        end else if (k >= ST_DV_B && k < ST_DV_B + DV_ST) begin
            y = dv_steps(x, k - ST_DV_B);
        end else if (k == ST_NRM) begin
            for (int i = 0; i < 3; i++) begin
                q = $signed({1'b0, x.quo[i]});
                if (x.root == '0) begin
                    y.nrm[i] = '0;
                end else begin
                    y.nrm[i] = x.neg[i] ? -q : q;
                end
            end
            n = -$signed(y.nrm[1]);
            y.dir[0] = DIR_W'(n);
            n = $signed(y.nrm[0]);
            y.dir[1] = DIR_W'(n);
            y.dir[2] = '0;
        end else if (k == ST_S1) begin
            for (int i = 0; i < 3; i++) begin
                q = $signed({1'b0, x.quo[i]});
                n = x.neg[i] ? -q : q;
                y.s1[i] = SID_W'(n);
            end
            if (x.root == '0) begin
                y.s1[0] = Q14_ONE;
                y.s1[1] = '0;
                y.s1[2] = '0;
            end
        end else if (k == ST_XMUL) begin
            pa = PRD_W'($signed(x.nrm[2])) * PRD_W'($signed(x.s1[1]));
            y.xp[0] = -pa;
            pa = PRD_W'($signed(x.nrm[2])) * PRD_W'($signed(x.s1[0]));
            y.xp[1] = pa;
            pa = PRD_W'($signed(x.nrm[0])) * PRD_W'($signed(x.s1[1]));
            pb = PRD_W'($signed(x.nrm[1])) * PRD_W'($signed(x.s1[0]));
            y.xp[2] = pa - pb;
        end else if (k == ST_XRND) begin
            for (int i = 0; i < 3; i++) begin
                r = rnd14($signed(x.xp[i]));
                y.s2[i] = r[SID_W-1:0];
            end
        end else if (k == ST_SMUL) begin
            sz = PRD_W'($signed({1'b0, x.size}));
            for (int i = 0; i < 3; i++) begin
                y.sp[i] = PRD_W'($signed(x.s1[i])) * sz;
                y.sp[3+i] = PRD_W'($signed(x.s2[i])) * sz;
            end
        end else if (k == ST_SRND) begin
            for (int j = 0; j < 6; j++) begin
                y.pp[j] = rnd14($signed(x.sp[j]));
            end
        end
        return y;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            align_mode_reg    <= ALIGN_SCREEN;
            custom_axis_reg   <= CUSTOM_AXIS_RST;
            camera_eye_reg    <= '0;
            camera_axis_reg   <= '0;
            system_offset_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_ALIGN_MODE:    align_mode_reg    <= cfg_wdata[1:0];
                REG_CUSTOM_AXIS:   custom_axis_reg   <= cfg_wdata;
                REG_CAMERA_EYE:    camera_eye_reg    <= cfg_wdata;
                REG_CAMERA_AXIS:   camera_axis_reg   <= cfg_wdata;
                REG_SYSTEM_OFFSET: system_offset_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        in_item = '0;
        in_item.pos[0] = s_pos_x;
        in_item.pos[1] = s_pos_y;
        in_item.pos[2] = s_pos_z;
        in_item.size = s_sprite_size;
        in_item.last = s_last_particle;
    end

    always_comb begin
        st_next[0] = stage_fn(0, in_item, align_mode_reg, camera_eye_reg, camera_axis_reg,
                              custom_axis_reg, system_offset_reg);
        for (int k = 1; k < NUM_ST; k++) begin
            st_next[k] = stage_fn(k, st_reg[k-1], align_mode_reg, camera_eye_reg,
                                  camera_axis_reg, custom_axis_reg, system_offset_reg);
        end
    end

    assign adv      = !vld_reg[NUM_ST-1] || (m_ready && cnt_reg == CORNER_LAST);
    assign vld_next = {vld_reg[NUM_ST-2:0], s_valid};
    assign cnt_next = cnt_reg + 2'd1;
    assign s_ready  = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < NUM_ST; k++) begin
                st_reg[k] <= st_next[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= CORNER_FIRST;
        end else if (m_valid && m_ready) begin
            cnt_reg <= cnt_next;
        end
    end

    assign oi = st_reg[NUM_ST-1];

    always_comb begin
        logic signed [SUM_W-1:0] v;
        for (int i = 0; i < 3; i++) begin
            v = SUM_W'($signed(oi.pos[i]));
            if (cnt_reg == CORNER_FIRST || cnt_reg == CORNER_LAST) begin
                v = v + SUM_W'($signed(oi.pp[i]));
            end else begin
                v = v - SUM_W'($signed(oi.pp[i]));
            end
            if (cnt_reg[1]) begin
                v = v + SUM_W'($signed(oi.pp[3+i]));
            end else begin
                v = v - SUM_W'($signed(oi.pp[3+i]));
            end
            vert[i] = sat_crd(v);
        end
    end

    assign m_valid        = vld_reg[NUM_ST-1];
    assign m_corner_index = cnt_reg;
    assign m_vert_x       = vert[0];
    assign m_vert_y       = vert[1];
    assign m_vert_z       = vert[2];
    assign m_norm_x       = oi.nrm[0];
    assign m_norm_y       = oi.nrm[1];
    assign m_norm_z       = oi.nrm[2];
    assign m_last_corner  = (cnt_reg == CORNER_LAST);
    assign m_end_of_set   = (cnt_reg == CORNER_LAST) && oi.last;

endmodule

/* rtl/bbq_checker.sv */
module bbq_checker
    import bbq_pkg::*;
(
    input logic                    aclk,
    input logic                    aresetn,
    input logic                    s_ready,
    input logic                    m_valid,
    input logic                    m_ready,
    input logic [1:0]              m_corner_index,
    input logic signed [CRD_W-1:0] m_vert_x,
    input logic signed [NRM_W-1:0] m_norm_x,
    input logic                    m_last_corner,
    input logic                    m_end_of_set
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_corner_index) && $stable(m_vert_x))
        else $error("result beat changed while stalled");

    a_burst: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_corner_index != CORNER_LAST |=>
            m_valid && m_corner_index == $past(m_corner_index) + 2'd1
            && $stable(m_norm_x))
        else $error("corners of one particle not back to back");

    a_end_set: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_end_of_set |-> m_last_corner && m_corner_index == CORNER_LAST)
        else $error("end of set off the last corner");

    a_no_take: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !(m_ready && m_corner_index == CORNER_LAST) |-> !s_ready)
        else $error("input taken while the output stage is busy");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind billboard_quad_generator bbq_checker u_bbq_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_corner_index (m_corner_index),
    .m_vert_x       (m_vert_x),
    .m_norm_x       (m_norm_x),
    .m_last_corner  (m_last_corner),
    .m_end_of_set   (m_end_of_set)
);

/* tb/tb.sv */
module tb;
    import bbq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        longint c[3];
    } v3_t;

    typedef struct {
        logic [1:0]       idx;
        logic [CRD_W-1:0] vx;
        logic [CRD_W-1:0] vy;
        logic [CRD_W-1:0] vz;
        logic [NRM_W-1:0] nx;
        logic [NRM_W-1:0] ny;
        logic [NRM_W-1:0] nz;
        logic             lc;
        logic             eos;
    } corner_t;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 48;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              cfg_we = 1'b0;
    logic [2:0]        cfg_index = REG_ALIGN_MODE;
    logic [VEC_W-1:0]  cfg_wdata = '0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [CRD_W-1:0]  s_pos_x = '0;
    logic [CRD_W-1:0]  s_pos_y = '0;
    logic [CRD_W-1:0]  s_pos_z = '0;
    logic [SIZE_W-1:0] s_sprite_size = '0;
    logic              s_last_particle = 1'b0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [1:0]        m_corner_index;
    logic [CRD_W-1:0]  m_vert_x;
    logic [CRD_W-1:0]  m_vert_y;
    logic [CRD_W-1:0]  m_vert_z;
    logic [NRM_W-1:0]  m_norm_x;
    logic [NRM_W-1:0]  m_norm_y;
    logic [NRM_W-1:0]  m_norm_z;
    logic              m_last_corner;
    logic              m_end_of_set;

    logic [1:0]       mdl_align = ALIGN_SCREEN;
    logic [VEC_W-1:0] mdl_custom = CUSTOM_AXIS_RST;
    logic [VEC_W-1:0] mdl_eye = '0;
    logic [VEC_W-1:0] mdl_cam = '0;
    logic [VEC_W-1:0] mdl_offset = '0;

    corner_t pending_corners[$];
    int      err_cnt = 0;
    int      cycle_cnt = 0;
    int      tx_idle_pct = 0;
    int      rx_idle_pct = 0;
    bit      rx_hold_req = 1'b0;
    int      rx_hold_cnt = 0;

    billboard_quad_generator i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_pos_x        (s_pos_x),
        .s_pos_y        (s_pos_y),
        .s_pos_z        (s_pos_z),
        .s_sprite_size  (s_sprite_size),
        .s_last_particle(s_last_particle),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_corner_index (m_corner_index),
        .m_vert_x       (m_vert_x),
        .m_vert_y       (m_vert_y),
        .m_vert_z       (m_vert_z),
        .m_norm_x       (m_norm_x),
        .m_norm_y       (m_norm_y),
        .m_norm_z       (m_norm_z),
        .m_last_corner  (m_last_corner),
        .m_end_of_set   (m_end_of_set)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic v3_t unpack_vec(input logic [VEC_W-1:0] r);
        v3_t v;
        v.c[0] = longint'($signed(r[19:0]));
        v.c[1] = longint'($signed(r[39:20]));
        v.c[2] = longint'($signed(r[59:40]));
        return v;
    endfunction

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint sqrt_floor(input longint x);
        longint r;
        longint t;
        r = 0;
        for (int b = 23; b >= 0; b--) begin
            t = r | (longint'(1) << b);
            if (t * t <= x) r = t;
        end
        return r;
    endfunction

    function automatic longint round_div(input longint num, input longint den);
        longint a;
        longint q;
        a = num < 0 ? -num : num;
        q = (2 * a + den) / (2 * den);
        return num < 0 ? -q : q;
    endfunction

    function automatic longint round_q14(input longint v);
        longint a;
        a = v < 0 ? -v : v;
        a = (a + 8192) >>> 14;
        return v < 0 ? -a : a;
    endfunction

    function automatic v3_t unit_vec(input v3_t v, output bit nonzero);
        v3_t o;
        longint l2;
        longint len;
        l2 = v.c[0] * v.c[0] + v.c[1] * v.c[1] + v.c[2] * v.c[2];
        nonzero = l2 != 0;
        for (int i = 0; i < 3; i++) o.c[i] = 0;
        if (nonzero) begin
            len = sqrt_floor(l2);
            for (int i = 0; i < 3; i++)
                o.c[i] = clip(round_div(v.c[i] * 16384, len), -32768, 32767);
        end
        return o;
    endfunction

    task automatic predict_quad(input logic [CRD_W-1:0] px, input logic [CRD_W-1:0] py,
                                input logic [CRD_W-1:0] pz, input logic [SIZE_W-1:0] sz,
                                input logic lst);
        v3_t off, eye, cam, cus, pos, dir, n, side, s1, s2, p1, p2;
        longint a, b;
        bit nz;
        corner_t cr;
        off = unpack_vec(mdl_offset);
        eye = unpack_vec(mdl_eye);
        cam = unpack_vec(mdl_cam);
        cus = unpack_vec(mdl_custom);
        pos.c[0] = clip(longint'($signed(px)) - off.c[0], -524288, 524287);
        pos.c[1] = clip(longint'($signed(py)) - off.c[1], -524288, 524287);
        pos.c[2] = clip(longint'($signed(pz)) - off.c[2], -524288, 524287);
        for (int i = 0; i < 3; i++) begin
            case (mdl_align)
                ALIGN_SCREEN: dir.c[i] = -cam.c[i];
                ALIGN_CAMERA, ALIGN_ZLOCK: dir.c[i] = eye.c[i] - pos.c[i];
                default: dir.c[i] = cus.c[i];
            endcase
        end
        if (mdl_align == ALIGN_ZLOCK) dir.c[2] = 0;
        n = unit_vec(dir, nz);
        side.c[0] = -n.c[1];
        side.c[1] = n.c[0];
        side.c[2] = 0;
        s1 = unit_vec(side, nz);
        if (!nz) begin
            s1.c[0] = 16384;
            s1.c[1] = 0;
            s1.c[2] = 0;
        end
        s2.c[0] = round_q14(n.c[1] * s1.c[2] - n.c[2] * s1.c[1]);
        s2.c[1] = round_q14(n.c[2] * s1.c[0] - n.c[0] * s1.c[2]);
        s2.c[2] = round_q14(n.c[0] * s1.c[1] - n.c[1] * s1.c[0]);
        for (int i = 0; i < 3; i++) begin
            p1.c[i] = round_q14(s1.c[i] * longint'(sz));
            p2.c[i] = round_q14(s2.c[i] * longint'(sz));
        end
        for (int k = 0; k < 4; k++) begin
            a = (k == 0 || k == 3) ? 1 : -1;
            b = (k >= 2) ? 1 : -1;
            cr.idx = 2'(k);
            cr.vx = CRD_W'(clip(pos.c[0] + a * p1.c[0] + b * p2.c[0], -524288, 524287));
            cr.vy = CRD_W'(clip(pos.c[1] + a * p1.c[1] + b * p2.c[1], -524288, 524287));
            cr.vz = CRD_W'(clip(pos.c[2] + a * p1.c[2] + b * p2.c[2], -524288, 524287));
            cr.nx = NRM_W'(n.c[0]);
            cr.ny = NRM_W'(n.c[1]);
            cr.nz = NRM_W'(n.c[2]);
            cr.lc = 2'(k) == CORNER_LAST;
            cr.eos = (2'(k) == CORNER_LAST) && lst;
            pending_corners.push_back(cr);
        end
    endtask

    task automatic report(input string what, input logic [63:0] want, input logic [63:0] got);
        $display("mismatch %s: expected %0h got %0h at %0t", what, want, got, $realtime);
        err_cnt++;
    endtask

    always @(posedge aclk) begin
        corner_t cr;
        if (m_valid && m_ready) begin
            if (pending_corners.size() == 0) begin
                report("unexpected beat", 0, 1);
            end else begin
                cr = pending_corners.pop_front();
                if (m_corner_index !== cr.idx) report("corner_index", cr.idx, m_corner_index);
                if (m_vert_x !== cr.vx) report("vert_x", cr.vx, m_vert_x);
                if (m_vert_y !== cr.vy) report("vert_y", cr.vy, m_vert_y);
                if (m_vert_z !== cr.vz) report("vert_z", cr.vz, m_vert_z);
                if (m_norm_x !== cr.nx) report("norm_x", cr.nx, m_norm_x);
                if (m_norm_y !== cr.ny) report("norm_y", cr.ny, m_norm_y);
                if (m_norm_z !== cr.nz) report("norm_z", cr.nz, m_norm_z);
                if (m_last_corner !== cr.lc) report("last_corner", cr.lc, m_last_corner);
                if (m_end_of_set !== cr.eos) report("end_of_set", cr.eos, m_end_of_set);
            end
        end
    end

    always @(posedge aclk) begin
        if (rx_hold_req && rx_hold_cnt == 0) begin
            rx_hold_req = 1'b0;
            rx_hold_cnt = 300;
        end
        if (rx_hold_cnt > 0) begin
            rx_hold_cnt--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= $urandom_range(99) >= rx_idle_pct;
        end
    end

    // call at a clock edge; returns at the edge where the beat is taken, or after a random idle gap
    task automatic send_particle(input logic [CRD_W-1:0] px, input logic [CRD_W-1:0] py,
                                 input logic [CRD_W-1:0] pz, input logic [SIZE_W-1:0] sz,
                                 input logic lst);
        s_valid <= 1'b1;
        s_pos_x <= px;
        s_pos_y <= py;
        s_pos_z <= pz;
        s_sprite_size <= sz;
        s_last_particle <= lst;
        do @(posedge aclk); while (!s_ready);
        predict_quad(px, py, pz, sz, lst);
        if ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge aclk);
        end
    endtask

    task automatic drain;
        s_valid <= 1'b0;
        while (pending_corners.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [VEC_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
        case (idx)
            REG_ALIGN_MODE:    mdl_align = val[1:0];
            REG_CUSTOM_AXIS:   mdl_custom = val;
            REG_CAMERA_EYE:    mdl_eye = val;
            REG_CAMERA_AXIS:   mdl_cam = val;
            REG_SYSTEM_OFFSET: mdl_offset = val;
            default: ;
        endcase
    endtask

    function automatic logic [VEC_W-1:0] rand_vec();
        logic [VEC_W-1:0] v;
        v = VEC_W'({$urandom, $urandom});
        case ($urandom_range(5))
            0: v = '0;
            1: v = '1;
            2: v = {20'h7ffff, 20'h80000, 20'h7ffff};
            3: v = {20'(12'($urandom)), 20'(12'($urandom)), 20'(12'($urandom))};
            default: ;
        endcase
        return v;
    endfunction

    function automatic logic [CRD_W-1:0] rand_crd();
        case ($urandom_range(9))
            0: return 20'h80000;
            1: return 20'h7ffff;
            2: return 20'($signed(14'($urandom)));
            default: return 20'($urandom);
        endcase
    endfunction

    task automatic send_random(input int count);
        logic [SIZE_W-1:0] sz;
        for (int i = 0; i < count; i++) begin
            sz = $urandom_range(3) == 0 ? 16'hffff : 16'($urandom);
            send_particle(rand_crd(), rand_crd(), rand_crd(), sz, $urandom_range(7) == 0);
        end
    endtask

    task automatic randomize_regs;
        write_reg(REG_ALIGN_MODE, VEC_W'($urandom_range(3)));
        write_reg(REG_CUSTOM_AXIS, rand_vec());
        write_reg(REG_CAMERA_EYE, rand_vec());
        write_reg(REG_CAMERA_AXIS, rand_vec());
        write_reg(REG_SYSTEM_OFFSET, rand_vec());
    endtask

    task automatic test_reset_defaults;
        // screen mode with a zero camera axis: zero normal
        send_particle(20'h00100, 20'h00200, 20'h00300, 16'h0100, 1'b0);
        send_particle(20'h7ffff, 20'h80000, 20'h7ffff, 16'hffff, 1'b1);
        send_particle(20'h80000, 20'h7ffff, 20'h80000, 16'h0000, 1'b0);
        drain();
    endtask

    task automatic test_align_modes;
        write_reg(REG_CAMERA_AXIS, {20'h00100, 20'hfff00, 20'h00080});
        write_reg(REG_CAMERA_EYE, {20'h01000, 20'h00500, 20'hff000});
        write_reg(REG_CUSTOM_AXIS, {20'h00100, 20'h0, 20'h0});
        write_reg(REG_SYSTEM_OFFSET, {20'h00010, 20'hffff0, 20'h00020});
        for (int m = 0; m < 4; m++) begin
            write_reg(REG_ALIGN_MODE, VEC_W'(m));
            send_particle(20'h00400, 20'h00300, 20'h00200, 16'h0200, 1'b0);
            send_particle(20'h7ffff, 20'h80000, 20'h00000, 16'hffff, 1'b1);
            drain();
        end
    endtask

    task automatic test_special_cases;
        // custom axis along z: side axis degenerates
        write_reg(REG_ALIGN_MODE, VEC_W'(ALIGN_CUSTOM));
        write_reg(REG_CUSTOM_AXIS, {20'h00100, 20'h0, 20'h0});
        send_particle(20'h00000, 20'h00000, 20'h00000, 16'h0180, 1'b1);
        drain();
        write_reg(REG_CUSTOM_AXIS, {20'hfff00, 20'h0, 20'h0});
        send_particle(20'h00010, 20'h00020, 20'h00030, 16'hffff, 1'b0);
        drain();
        // camera at the particle: zero direction
        write_reg(REG_ALIGN_MODE, VEC_W'(ALIGN_CAMERA));
        write_reg(REG_CAMERA_EYE, {20'h00300, 20'h00200, 20'h00100});
        write_reg(REG_SYSTEM_OFFSET, '0);
        send_particle(20'h00100, 20'h00200, 20'h00300, 16'h0400, 1'b1);
        drain();
        // offset drives the relative position into saturation
        write_reg(REG_ALIGN_MODE, VEC_W'(ALIGN_ZLOCK));
        write_reg(REG_SYSTEM_OFFSET, {20'h7ffff, 20'h80000, 20'h7ffff});
        send_particle(20'h80000, 20'h7ffff, 20'h80000, 16'hffff, 1'b0);
        drain();
        // writes beyond the register list do nothing
        write_reg(3'd5, '1);
        write_reg(3'd7, '1);
        send_particle(20'h00123, 20'hfedcb, 20'h00abc, 16'h8000, 1'b1);
        drain();
    endtask

    task automatic test_random_phase(input int tx_pct, input int rx_pct);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        for (int k = 0; k < 4; k++) begin
            randomize_regs();
            send_random(20);
            drain();
        end
    endtask

    task automatic test_back_pressure;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        rx_hold_req = 1'b1;
        send_random(50);
        drain();
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_defaults();
        test_align_modes();
        test_special_cases();
        test_random_phase(26, 55);
        test_random_phase(55, 26);
        test_random_phase(0, 0);
        test_back_pressure();
        if (err_cnt == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
